### rtl/brr_pkg.sv
// Shared types, status codes and AES helpers for the RPA resolver.
// No dependencies; used by brr_aes and ble_rpa_resolver.
`default_nettype none
package brr_pkg;

  localparam logic [2:0] ST_MATCH    = 3'd0;
  localparam logic [2:0] ST_NOMATCH  = 3'd1;
  localparam logic [2:0] ST_NOTRES   = 3'd2;
  localparam logic [2:0] ST_ADDED    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_DUP      = 3'd5;

  localparam logic       CMD_RESOLVE = 1'b0;
  localparam logic       CMD_ADD     = 1'b1;

  localparam logic [1:0] RPA_TAG     = 2'b01;

  typedef logic [127:0] blk_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits in bits 127-8i -: 8 (byte 0 most significant).
  function automatic logic [7:0] byte_of(input blk_t b, input int i);
    return b[127-8*i -: 8];
  endfunction

  // Next round key from the current one and its round constant.
  function automatic blk_t key_next(input blk_t k, input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    blk_t r;
    for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
    t = {sbox(w[3][23:16]) ^ rc, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    r = {w[0], w[1], w[2], w[3]};
    return r;
  endfunction

  // SubBytes, ShiftRows and (unless last) MixColumns.
  function automatic blk_t round_fn(input blk_t s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    blk_t r;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        t[i*4+j] = sbox(byte_of(s, ((i + j) % 4) * 4 + j));
    if (!last) begin
      for (int i = 0; i < 4; i++) begin
        a0 = t[i*4]; a1 = t[i*4+1]; a2 = t[i*4+2]; a3 = t[i*4+3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        t[i*4]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[i*4+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[i*4+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[i*4+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/brr_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module brr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register read data
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### rtl/brr_aes.sv
// Iterative AES-128 encryption core, one round per cycle.
// Depends on brr_pkg.
`default_nettype none
module brr_aes (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire brr_pkg::blk_t key,
  input  wire brr_pkg::blk_t pt,
  output logic               done,
  output brr_pkg::blk_t      ct
);
  brr_pkg::blk_t st_r, rk_r;
  logic [7:0]    rc_r;
  logic [3:0]    rnd_r;
  logic          run_r;
  brr_pkg::blk_t rk_nxt, st_nxt;

  assign rk_nxt = brr_pkg::key_next(rk_r, rc_r);
  assign st_nxt = brr_pkg::round_fn(st_r, rnd_r == 4'd10) ^ rk_nxt;

  // Load whitened block, then advance one round a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      rnd_r <= 4'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        rnd_r <= 4'd1;
      end else if (run_r) begin
        rnd_r <= rnd_r + 4'd1;
        if (rnd_r == 4'd10) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      st_r <= pt ^ key;
      rk_r <= key;
      rc_r <= 8'h01;
    end else if (run_r) begin
      st_r <= st_nxt;
      rk_r <= rk_nxt;
      rc_r <= brr_pkg::xtime(rc_r);
    end
  end

  assign ct = st_r;
endmodule
`default_nettype wire

### rtl/ble_rpa_resolver.sv
// Resolvable private address resolver: a key table in two RAMs walked by
// a sequencer driving an iterative AES core. Each command gives one result
// strobe (out_valid); the receiver cannot stall. An add scans the N stored
// keys for a duplicate (one RAM read per key); a resolve runs the ten-round
// AES core per stored key. No clearing pass after reset.
// Depends on brr_pkg, brr_ram, brr_aes.
`default_nettype none
module ble_rpa_resolver #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [47:0] in_address,
  input  wire logic [63:0] in_irk_high,
  input  wire logic [63:0] in_irk_low,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [3:0]       out_entry_index,
  output logic [4:0]       out_entries_used
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RD = 1 << AW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_AES  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_r;
  logic          cmd_r;
  logic [47:0]   addr_r;
  logic [63:0]   hi_r, lo_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic [2:0]    res_st_r;
  logic [CW-1:0] res_idx_r;
  logic          we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   rd_hi, rd_lo;
  logic          aes_go, aes_done;
  brr_pkg::blk_t ct;

  assign busy = (state_r != S_IDLE);
  assign we   = (state_r == S_DONE) && (res_st_r == brr_pkg::ST_ADDED);
  assign ram_addr = idx_r[AW-1:0];

  brr_ram #(.WIDTH(64), .DEPTH(RD)) u_hi (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(hi_r), .rdata(rd_hi));
  brr_ram #(.WIDTH(64), .DEPTH(RD)) u_lo (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(lo_r), .rdata(rd_lo));

  assign aes_go = (state_r == S_AES);
  brr_aes u_aes (
    .clk(clk), .rst_n(rst_n), .go(aes_go), .key({rd_hi, rd_lo}),
    .pt({104'd0, addr_r[47:24]}), .done(aes_done), .ct(ct));

  // Sequencer: scan stored entries, one read per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r  <= in_cmd;
            addr_r <= in_address;
            hi_r   <= in_irk_high;
            lo_r   <= in_irk_low;
            idx_r  <= '0;
            res_idx_r <= '0;
            if (in_cmd == brr_pkg::CMD_ADD && cnt_r >= CW'(MAX_ENTRIES)) begin
              res_st_r <= brr_pkg::ST_FULL;
              state_r  <= S_DONE;
            end else if (in_cmd == brr_pkg::CMD_RESOLVE &&
                         in_address[47:46] != brr_pkg::RPA_TAG) begin
              res_st_r <= brr_pkg::ST_NOTRES;
              state_r  <= S_DONE;
            end else if (cnt_r == '0) begin
              res_st_r <= (in_cmd == brr_pkg::CMD_ADD) ? brr_pkg::ST_ADDED
                                                      : brr_pkg::ST_NOMATCH;
              state_r  <= S_DONE;
            end else begin
              state_r  <= S_RD;
            end
          end
        end
        S_RD: state_r <= (cmd_r == brr_pkg::CMD_ADD) ? S_CMP : S_AES;
        S_CMP: begin
          if (rd_hi == hi_r && rd_lo == lo_r) begin
            res_st_r <= brr_pkg::ST_DUP;
            state_r  <= S_DONE;
          end else if (idx_r + CW'(1) == cnt_r) begin
            idx_r     <= cnt_r;
            res_idx_r <= cnt_r;
            res_st_r  <= brr_pkg::ST_ADDED;
            state_r   <= S_DONE;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_RD;
          end
        end
        S_AES: state_r <= S_WAIT;
        S_WAIT: begin
          if (aes_done) begin
            if (ct[23:0] == addr_r[23:0]) begin
              res_st_r  <= brr_pkg::ST_MATCH;
              res_idx_r <= idx_r;
              state_r   <= S_DONE;
            end else if (idx_r + CW'(1) == cnt_r) begin
              res_st_r <= brr_pkg::ST_NOMATCH;
              state_r  <= S_DONE;
            end else begin
              idx_r   <= idx_r + CW'(1);
              state_r <= S_RD;
            end
          end
        end
        S_DONE: begin
          // An add writes this cycle via we; report the transaction
          out_valid       <= 1'b1;
          out_status      <= res_st_r;
          out_entry_index <= 4'(res_idx_r);
          if (res_st_r == brr_pkg::ST_ADDED) begin
            cnt_r            <= cnt_r + CW'(1);
            out_entries_used <= 5'(cnt_r + CW'(1));
          end else begin
            out_entries_used <= 5'(cnt_r);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Count never passes capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES)) else $error("entry count over capacity");
  // A result strobe follows the done step
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid) else $error("missing result strobe");
  // Accepted command makes block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("command not taken");
endmodule
`default_nettype wire
